>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

>>> design/swsfr_pkg.sv
// ---------------------------------------------------------------------------
// swsfr_pkg
// Types and constants of the single-wire sensor frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package swsfr_pkg;

  localparam int EDGE_SLOTS = 42;
  localparam int SKIP_EDGES = 2;

  localparam int THR_W    = 10;
  localparam int MS_W     = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W    = 8;
  localparam int DATA_W   = 32;
  localparam int CHECK_W  = 8;

  localparam logic [IDX_W-1:0] DATA_FIRST    = IDX_W'(SKIP_EDGES);
  localparam logic [IDX_W-1:0] CHECK_FIRST   = IDX_W'(SKIP_EDGES + DATA_W);
  localparam logic [IDX_W-1:0] CHECK_END     = IDX_W'(SKIP_EDGES + DATA_W + CHECK_W);
  localparam logic [IDX_W-1:0] LAST_EDGE     = IDX_W'(SKIP_EDGES + DATA_W + CHECK_W - 1);
  localparam logic [IDX_W-1:0] DATA_MSB_POS  = IDX_W'(SKIP_EDGES + DATA_W - 1);
  localparam logic [IDX_W-1:0] CHECK_MSB_POS = IDX_W'(SKIP_EDGES + DATA_W + CHECK_W - 1);
  localparam logic [IDX_W:0]   SLOT_COUNT    = (IDX_W + 1)'(EDGE_SLOTS);

  localparam logic [THR_W-1:0] THR_RESET    = THR_W'(90);
  localparam logic [MS_W-1:0]  START_RESET  = MS_W'(2500);
  localparam logic [MS_W-1:0]  PERIOD_RESET = MS_W'(9000);

  localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_PERIOD  = 2'd2;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_READING = 2'd1,
    ST_DONE    = 2'd2
  } status_e;

  typedef struct packed {
    logic                 line_release;
    logic [DATA_W-1:0]    data_word;
    logic [CHECK_W-1:0]   check_byte;
    status_e              link_status;
    logic                 frame_done;
  } result_t;

endpackage

`default_nettype wire

>>> design/swsfr_in_if.sv
// ---------------------------------------------------------------------------
// swsfr_in_if
// Event channel: edge or millisecond tick, with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface swsfr_in_if import swsfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [THR_W-1:0] pulse_us;

  modport source (output valid, output command, output pulse_us, input ready);
  modport sink   (input valid, input command, input pulse_us, output ready);
endinterface

`default_nettype wire

>>> design/swsfr_out_if.sv
// ---------------------------------------------------------------------------
// swsfr_out_if
// Result channel: line drive, received words and link status.
// ---------------------------------------------------------------------------
`default_nettype none

interface swsfr_out_if import swsfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               line_release;
  logic [DATA_W-1:0]  data_word;
  logic [CHECK_W-1:0] check_byte;
  logic [1:0]         link_status;
  logic               frame_done;

  modport source (output valid, output line_release, output data_word,
                  output check_byte, output link_status, output frame_done,
                  input ready);
  modport sink   (input valid, input line_release, input data_word,
                  input check_byte, input link_status, input frame_done,
                  output ready);
endinterface

`default_nettype wire

>>> design/single_wire_sensor_frame_receiver.sv
// ---------------------------------------------------------------------------
// single_wire_sensor_frame_receiver
// Decodes line edge intervals into a 40 bit frame and times the start pulse.
// ---------------------------------------------------------------------------
//  channel  dir  transaction
//  evt_i    in   command (edge/tick), pulse_us
//  res_o    out  line_release, data_word, check_byte, link_status, frame_done
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
//  One event per clock while the skid is empty; each result is registered as its event is accepted.
//  State update and result fit in a single pass of compare/shift logic.
//  A two-entry result buffer (output register plus skid) keeps evt_i ready
//  while one result waits on a stalled res_o.
//  Reset restores register defaults, resets the decoder state and empties the result buffer; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module single_wire_sensor_frame_receiver import swsfr_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  swsfr_in_if.sink                  evt_i,
  swsfr_out_if.source               res_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  logic [THR_W-1:0]   thr_q;
  logic [MS_W-1:0]    start_q;
  logic [MS_W-1:0]    period_q;

  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [MS_W-1:0]    ms_q, ms_d;
  logic [DATA_W-1:0]  data_q, data_d;
  logic [CHECK_W-1:0] check_q, check_d;
  status_e            status_q, status_d;
  logic               line_q, line_d;
  logic               done_d;

  logic [IDX_W-1:0]   data_pos, check_pos;
  logic [IDX_W:0]     idx_inc;
  logic [MS_W:0]      ms_inc, start_p1;
  logic               rx_bit;

  result_t            res_d, out_q, skid_q;
  logic               out_valid_q, skid_valid_q;
  logic               in_fire, out_fire;

  assign evt_i.ready = !skid_valid_q;
  assign in_fire     = evt_i.valid && !skid_valid_q;
  assign out_fire    = out_valid_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_RESET;
      start_q  <= START_RESET;
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BIT_THRESHOLD: thr_q    <= cfg_data_i[THR_W-1:0];
        REG_START_TIME:    start_q  <= cfg_data_i[MS_W-1:0];
        REG_CYCLE_PERIOD:  period_q <= cfg_data_i[MS_W-1:0];
        default:           ;
      endcase
    end
  end

  assign rx_bit    = evt_i.pulse_us > thr_q;
  assign data_pos  = DATA_MSB_POS - idx_q;
  assign check_pos = CHECK_MSB_POS - idx_q;
  assign idx_inc   = {1'b0, idx_q} + 1'b1;
  assign ms_inc    = {1'b0, ms_q} + 1'b1;
  assign start_p1  = {1'b0, start_q} + 1'b1;

  always_comb begin
    idx_d    = idx_q;
    ms_d     = ms_q;
    data_d   = data_q;
    check_d  = check_q;
    status_d = status_q;
    line_d   = line_q;
    done_d   = 1'b0;
    if (evt_i.command == CMD_EDGE) begin
      status_d = ST_READING;
      if (idx_q >= DATA_FIRST && idx_q < CHECK_FIRST) begin
        data_d = data_q | ({{(DATA_W-1){1'b0}}, rx_bit} << data_pos[4:0]);
      end
      if (idx_q >= CHECK_FIRST && idx_q < CHECK_END) begin
        check_d = check_q | ({{(CHECK_W-1){1'b0}}, rx_bit} << check_pos[2:0]);
        if (idx_q == LAST_EDGE) begin
          ms_d     = '0;
          status_d = ST_DONE;
          done_d   = 1'b1;
        end
      end
      idx_d = (idx_inc >= SLOT_COUNT) ? '0 : idx_inc[IDX_W-1:0];
    end else begin
      ms_d = (ms_inc > {1'b0, period_q}) ? '0 : ms_inc[MS_W-1:0];
      if ({1'b0, ms_d} > start_p1) begin
        if (!line_q) begin
          idx_d = '0;
        end
        line_d = 1'b1;
      end else if (ms_d >= start_q) begin
        data_d  = '0;
        check_d = '0;
        line_d  = 1'b0;
        idx_d   = '0;
      end
    end
  end

  always_comb begin
    res_d.line_release = line_d;
    res_d.data_word    = data_d;
    res_d.check_byte   = check_d;
    res_d.link_status  = status_d;
    res_d.frame_done   = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ms_q     <= '0;
      data_q   <= '0;
      check_q  <= '0;
      status_q <= ST_IDLE;
      line_q   <= 1'b1;
    end else if (in_fire) begin
      idx_q    <= idx_d;
      ms_q     <= ms_d;
      data_q   <= data_d;
      check_q  <= check_d;
      status_q <= status_d;
      line_q   <= line_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= in_fire;
      end else begin
        out_valid_q  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (in_fire) begin
          skid_q <= res_d;
        end
      end else if (in_fire) begin
        out_q <= res_d;
      end
    end else if (in_fire) begin
      skid_q <= res_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.line_release = out_q.line_release;
  assign res_o.data_word    = out_q.data_word;
  assign res_o.check_byte   = out_q.check_byte;
  assign res_o.link_status  = out_q.link_status;
  assign res_o.frame_done   = out_q.frame_done;

endmodule

`default_nettype wire

>>> design/swsfr_checker.sv
// ---------------------------------------------------------------------------
// swsfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module swsfr_checker import swsfr_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_release,
  input wire logic [DATA_W-1:0]  out_data,
  input wire logic [CHECK_W-1:0] out_check,
  input wire logic [1:0]         out_status,
  input wire logic               out_done
);

  // stalled result holds
  `ASSERT_CLK_RST(a_out_hold, clk_i, rst_ni,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)
      && $stable(out_check) && $stable(out_status) && $stable(out_done)
      && $stable(out_release)))

  // a new result needs an accepted event
  `ASSERT_CLK_RST(a_out_from_in, clk_i, rst_ni,
    $rose(out_valid) |-> $past(in_valid && in_ready))

  // input stays open while the output side is empty
  `ASSERT_CLK_RST(a_ready_when_empty, clk_i, rst_ni,
    !out_valid |-> in_ready)

  // frame completion always reports done status
  `ASSERT_CLK(a_done_status, clk_i,
    (out_valid && out_done) |-> (out_status == ST_DONE))

endmodule

bind single_wire_sensor_frame_receiver swsfr_checker u_swsfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (evt_i.valid),
  .in_ready    (evt_i.ready),
  .out_valid   (res_o.valid),
  .out_ready   (res_o.ready),
  .out_release (res_o.line_release),
  .out_data    (res_o.data_word),
  .out_check   (res_o.check_byte),
  .out_status  (res_o.link_status),
  .out_done    (res_o.frame_done)
);

`default_nettype wire

>>> verif/swsfr_frame_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swsfr_frame_check
// Watches the event, result and register ports of the frame receiver, keeps
// its own model of the edge decoder and millisecond timer, and compares each
// result transaction field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module swsfr_frame_check import swsfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  swsfr_in_if                  evt,
  swsfr_out_if                 res,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          checked_o,
  output int unsigned          frames_o,
  output int unsigned          low_results_o
);

  localparam int MaxPrinted = 100;

  logic [THR_W-1:0]   thr_q;
  logic [MS_W-1:0]    start_q;
  logic [MS_W-1:0]    period_q;
  logic [IDX_W-1:0]   edge_idx;
  logic [MS_W-1:0]    ms_cnt;
  logic [DATA_W-1:0]  data_acc;
  logic [CHECK_W-1:0] check_acc;
  status_e            status_q;
  logic               line_q;

  result_t     pending_snapshots[$];
  result_t     want;
  int unsigned fail_total = 0;
  int unsigned checked_total = 0;
  int unsigned frames_total = 0;
  int unsigned low_total = 0;
  int unsigned pending_n = 0;

  assign fail_count_o  = fail_total;
  assign pending_o     = pending_n;
  assign checked_o     = checked_total;
  assign frames_o      = frames_total;
  assign low_results_o = low_total;

  task automatic report_failure(string msg);
    if (fail_total < MaxPrinted) begin
      $display("ERROR t=%0t: %s", $realtime, msg);
    end
    fail_total++;
  endtask

  task automatic compare_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] wanted);
    if (got !== wanted) begin
      report_failure($sformatf("result %0d: %s is 0x%0h, predicted 0x%0h",
                               checked_total, name, got, wanted));
    end
  endtask

  // One event in, one line snapshot out.
  function automatic result_t decode_event(logic cmd, logic [THR_W-1:0] pulse);
    result_t     r;
    logic        bit_val;
    logic [16:0] next_ms;
    r.frame_done = 1'b0;
    if (cmd == CMD_EDGE) begin
      bit_val  = (pulse > thr_q);
      status_q = ST_READING;
      if (edge_idx >= DATA_FIRST && edge_idx < CHECK_FIRST) begin
        data_acc |= DATA_W'(bit_val) << (DATA_MSB_POS - edge_idx);
      end else if (edge_idx >= CHECK_FIRST && edge_idx < CHECK_END) begin
        check_acc |= CHECK_W'(bit_val) << (CHECK_MSB_POS - edge_idx);
        if (edge_idx == LAST_EDGE) begin
          ms_cnt       = '0;
          status_q     = ST_DONE;
          r.frame_done = 1'b1;
        end
      end
      if (int'(edge_idx) + 1 >= EDGE_SLOTS) begin
        edge_idx = '0;
      end else begin
        edge_idx = edge_idx + 8'd1;
      end
    end else begin
      next_ms = {1'b0, ms_cnt} + 17'd1;
      if (next_ms > {1'b0, period_q}) begin
        next_ms = '0;
      end
      ms_cnt = next_ms[MS_W-1:0];
      if (next_ms > {1'b0, start_q} + 17'd1) begin
        // index is cleared once more on the releasing tick only
        if (!line_q) begin
          edge_idx = '0;
        end
        line_q = 1'b1;
      end else if (next_ms >= {1'b0, start_q}) begin
        data_acc  = '0;
        check_acc = '0;
        line_q    = 1'b0;
        edge_idx  = '0;
      end
    end
    r.line_release = line_q;
    r.data_word    = data_acc;
    r.check_byte   = check_acc;
    r.link_status  = status_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     = THR_RESET;
      start_q   = START_RESET;
      period_q  = PERIOD_RESET;
      edge_idx  = '0;
      ms_cnt    = '0;
      data_acc  = '0;
      check_acc = '0;
      status_q  = ST_IDLE;
      line_q    = 1'b1;
      pending_snapshots.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (pending_snapshots.size() == 0) begin
          report_failure($sformatf("result %0d arrived with nothing predicted",
                                   checked_total));
        end else begin
          want = pending_snapshots.pop_front();
          compare_field("line_release", DATA_W'(res.line_release),
                        DATA_W'(want.line_release));
          compare_field("data_word", res.data_word, want.data_word);
          compare_field("check_byte", DATA_W'(res.check_byte), DATA_W'(want.check_byte));
          compare_field("link_status", DATA_W'(res.link_status),
                        DATA_W'(want.link_status));
          compare_field("frame_done", DATA_W'(res.frame_done), DATA_W'(want.frame_done));
          if (want.frame_done) frames_total++;
          if (!want.line_release) low_total++;
        end
        checked_total++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BIT_THRESHOLD: thr_q    = cfg_data_i[THR_W-1:0];
          REG_START_TIME:    start_q  = cfg_data_i[MS_W-1:0];
          REG_CYCLE_PERIOD:  period_q = cfg_data_i[MS_W-1:0];
          default: ;
        endcase
      end
      if (evt.valid && evt.ready) begin
        pending_snapshots.push_back(decode_event(evt.command, evt.pulse_us));
      end
    end
    pending_n = pending_snapshots.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the single-wire sensor frame receiver: directed edges and
// ticks at the field and register extremes, then random sensor frames,
// broken frames and noise under several register settings and handshake
// stall patterns, then a full frame under the latest start time.
// ---------------------------------------------------------------------------
module tb;
  import swsfr_pkg::*;

  localparam int StallLimit  = 5000;
  localparam int PhaseItems  = 120;
  localparam int HoldCycles  = 60;
  localparam int FrameEdges  = SKIP_EDGES + DATA_W + CHECK_W;
  localparam int SettleTicks = 8;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  int unsigned      src_idle_pct = 0;
  int unsigned      snk_idle_pct = 0;
  bit               hold_request = 1'b0;
  logic [THR_W-1:0] cur_thr = THR_RESET;
  logic [MS_W-1:0]  cur_period = PERIOD_RESET;
  int unsigned      events_sent = 0;
  int unsigned      settings_used = 1;
  int unsigned      stall_cycles = 0;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned results_checked;
  int unsigned frames_done;
  int unsigned low_results;

  swsfr_in_if  evt_if();
  swsfr_out_if res_if();

  single_wire_sensor_frame_receiver dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  swsfr_frame_check frame_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .evt           (evt_if),
    .res           (res_if),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count),
    .checked_o     (results_checked),
    .frames_o      (frames_done),
    .low_results_o (low_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side: random backpressure, plus one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("no transaction for %0d cycles", StallLimit);
    $display("single_wire_sensor_frame_receiver regression: fail");
    $finish;
  end

  task automatic send_event(logic cmd, logic [THR_W-1:0] pulse);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      evt_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    evt_if.valid    <= 1'b1;
    evt_if.command  <= cmd;
    evt_if.pulse_us <= pulse;
    do @(posedge clk_i); while (!evt_if.ready);
    events_sent++;
  endtask

  task automatic send_tick();
    send_event(CMD_TICK, THR_W'($urandom_range(999)));
  endtask

  function automatic logic [THR_W-1:0] pick_pulse();
    int lo;
    int hi;
    lo = (int'(cur_thr) > 20) ? int'(cur_thr) - 20 : 0;
    hi = (int'(cur_thr) < 979) ? int'(cur_thr) + 20 : 999;
    if ($urandom_range(3) == 0) return THR_W'($urandom_range(999));
    return THR_W'($urandom_range(hi, lo));
  endfunction

  task automatic send_frame(int lead, int edges);
    repeat (lead) send_tick();
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(59) == 0) send_tick();
      send_event(CMD_EDGE, pick_pulse());
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    evt_if.valid <= 1'b0;
    wait (pending_count == 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(logic [THR_W-1:0] thr, logic [MS_W-1:0] start,
                               logic [MS_W-1:0] period);
    drain();
    write_reg(REG_BIT_THRESHOLD, CFG_W'(thr));
    write_reg(REG_START_TIME, CFG_W'(start));
    write_reg(REG_CYCLE_PERIOD, CFG_W'(period));
    cur_thr    = thr;
    cur_period = period;
    settings_used++;
  endtask

  initial begin
    int phase_end;
    int pick;
    int lead;
    int s;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_BIT_THRESHOLD;
    cfg_data        = '0;
    evt_if.valid    = 1'b0;
    evt_if.command  = CMD_EDGE;
    evt_if.pulse_us = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 19;
    snk_idle_pct = 50;

    // reset settings: skipped edges, threshold boundary, ticks
    send_event(CMD_EDGE, THR_W'(0));
    send_event(CMD_EDGE, THR_W'(999));
    send_event(CMD_EDGE, THR_RESET);
    send_event(CMD_EDGE, THR_RESET + THR_W'(1));
    send_event(CMD_EDGE, THR_W'(999));
    send_tick();
    send_tick();
    send_event(CMD_EDGE, THR_W'(0));
    // zero threshold, start at zero, period just past the start
    apply_setting(THR_W'(0), MS_W'(0), MS_W'(1));
    send_event(CMD_EDGE, THR_W'(0));
    send_event(CMD_EDGE, THR_W'(1));
    send_tick();
    send_tick();
    send_event(CMD_EDGE, THR_W'(512));
    send_tick();
    // top threshold, latest start, longest period
    apply_setting(THR_W'(999), MS_W'(65533), MS_W'(65535));
    send_event(CMD_EDGE, THR_W'(999));
    send_event(CMD_EDGE, THR_W'(998));
    send_tick();
    // full start pulse and release
    apply_setting(THR_W'(500), MS_W'(3), MS_W'(6));
    repeat (8) send_tick();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          s = $urandom_range(10, 2);
          apply_setting(THR_RESET, MS_W'(s), MS_W'(s + $urandom_range(30, 4)));
        end
        1: begin
          s = $urandom_range(20);
          apply_setting(THR_W'($urandom_range(999)), MS_W'(s),
                        MS_W'(s + $urandom_range(40, 1)));
        end
        2: apply_setting(THR_W'(999), MS_W'(1), MS_W'(12));
        3: apply_setting(THR_W'(0), MS_W'(0), MS_W'(1));
        4: apply_setting(THR_W'($urandom_range(998, 1)), MS_W'($urandom_range(30)),
                         MS_W'($urandom_range(60, 1)));
        default: begin
          s = $urandom_range(12, 2);
          apply_setting(THR_W'($urandom_range(999)), MS_W'(s),
                        MS_W'(s + $urandom_range(20, 2)));
        end
      endcase
      if (p < 2) begin
        src_idle_pct = 19;
        snk_idle_pct = 50;
      end else if (p < 4) begin
        src_idle_pct = 50;
        snk_idle_pct = 19;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (p == 0 || p == 4) hold_request = 1'b1;
      phase_end = events_sent + PhaseItems;
      while (events_sent < phase_end) begin
        pick = $urandom_range(9);
        if (pick < 7) begin
          lead = $urandom_range((int'(cur_period) + 3 < 60) ? int'(cur_period) + 3 : 60);
          send_frame(lead, FrameEdges);
        end else if (pick == 7) begin
          send_frame($urandom_range(3), $urandom_range(45, 1));
        end else begin
          repeat ($urandom_range(8, 1)) begin
            send_event(1'($urandom_range(1)), THR_W'($urandom_range(999)));
          end
        end
      end
    end

    // a frame with the start pulse out of reach
    apply_setting(THR_W'($urandom_range(999)), MS_W'(65533), MS_W'(65535));
    send_frame(4, FrameEdges);

    drain();
    repeat (SettleTicks) @(posedge clk_i);
    $display("covered %0d events under %0d register settings, incl. stalls and drains",
             events_sent, settings_used);
    $display("%0d results checked, %0d frames completed, %0d with the line held low",
             results_checked, frames_done, low_results);
    if (fail_count == 0) begin
      $display("single_wire_sensor_frame_receiver regression: pass");
    end else begin
      $display("single_wire_sensor_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule
